// File: src/salc_pkg.sv
// Shared types and codes for the set-associative write-back cache.
package salc_pkg;

  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;
  localparam int AGE_W    = 16;

  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_PRELOAD = 2'd3;

  localparam logic [ACTION_W-1:0] ACT_TO_CPU    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FROM_CPU  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FILL      = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITEBACK = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DISCARD   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_FLUSH     = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_PRELOAD   = 3'd6;

  localparam logic [1:0] CFG_BLOCK = 2'd0;
  localparam logic [1:0] CFG_SETS  = 2'd1;
  localparam logic [1:0] CFG_WAYS  = 2'd2;

  // Request passed from the front end to the back end.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   block_address;
    logic [DATA_W-1:0]   read_data;
    logic                last;
  } res_t;

endpackage

// File: src/salc_front.sv
// Input stage and request queue between the stream input and the cache engine.
module salc_front #(
  parameter int DEPTH_LOG2 = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  salc_pkg::req_t in_req,
  output logic           q_valid,
  input  logic           q_ready,
  output salc_pkg::req_t q_req
);
  import salc_pkg::*;

  localparam int DEPTH = 1 << DEPTH_LOG2;

  req_t                  fifo [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr;
  logic [DEPTH_LOG2-1:0] rd_ptr;
  logic [DEPTH_LOG2:0]   count;
  logic                  push;
  logic                  pop;

  assign in_ready = (count != DEPTH[DEPTH_LOG2:0]);
  assign q_valid  = (count != '0);
  assign q_req    = fifo[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Store accepted items.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_req;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: src/salc_back.sv
// Cache engine: tag lookup, age update, eviction, fill, access, flush and preload.
module salc_back #(
  parameter int MEM_WORDS       = 65536,
  parameter int MAX_BLOCK_WORDS = 16,
  parameter int MAX_SETS        = 16,
  parameter int MAX_WAYS        = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [2:0]     block_words_log2,
  input  logic [2:0]     sets_log2,
  input  logic [1:0]     ways_log2,
  input  logic           q_valid,
  output logic           q_ready,
  input  salc_pkg::req_t q_req,
  output logic           res_valid,
  input  logic           res_ready,
  output salc_pkg::res_t res
);
  import salc_pkg::*;

  localparam int MEM_AW  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int BW_L2   = $clog2(MAX_BLOCK_WORDS);
  localparam int SET_L2  = $clog2(MAX_SETS);
  localparam int WAY_L2  = $clog2(MAX_WAYS);
  localparam int BW_W    = (BW_L2 > 0) ? BW_L2 : 1;
  localparam int SET_W   = (SET_L2 > 0) ? SET_L2 : 1;
  localparam int WAY_W   = (WAY_L2 > 0) ? WAY_L2 : 1;
  localparam int NLINES  = MAX_SETS * MAX_WAYS;
  localparam int LINE_W  = SET_L2 + WAY_L2 + 1;
  localparam int LI_W    = (SET_L2 + WAY_L2 > 0) ? SET_L2 + WAY_L2 : 1;
  localparam int DW_W    = SET_L2 + WAY_L2 + BW_L2 + 1;
  localparam int DA_W    = (SET_L2 + WAY_L2 + BW_L2 > 0) ? SET_L2 + WAY_L2 + BW_L2 : 1;
  localparam int BCNT_W  = BW_L2 + 1;
  localparam int SCNT_W  = SET_L2 + 1;
  localparam int WCNT_W  = WAY_L2 + 1;
  localparam int CLR_W   = MEM_AW + 1;

  localparam logic [4:0] ST_CLEAR  = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_SCAN   = 5'd2;
  localparam logic [4:0] ST_VICT   = 5'd3;
  localparam logic [4:0] ST_VREAD  = 5'd4;
  localparam logic [4:0] ST_WB     = 5'd5;
  localparam logic [4:0] ST_EVREC  = 5'd6;
  localparam logic [4:0] ST_FREAD  = 5'd7;
  localparam logic [4:0] ST_FILL   = 5'd8;
  localparam logic [4:0] ST_FREC   = 5'd9;
  localparam logic [4:0] ST_ACC    = 5'd10;
  localparam logic [4:0] ST_AREAD  = 5'd11;
  localparam logic [4:0] ST_AREC   = 5'd12;
  localparam logic [4:0] ST_FLINE  = 5'd13;
  localparam logic [4:0] ST_FREADW = 5'd14;
  localparam logic [4:0] ST_FWB    = 5'd15;
  localparam logic [4:0] ST_FNEXT  = 5'd16;
  localparam logic [4:0] ST_PRE    = 5'd17;
  localparam logic [4:0] ST_WAIT   = 5'd18;
  localparam logic [4:0] ST_WREAD  = 5'd19;
  localparam logic [4:0] ST_VTAG   = 5'd20;

  // Memories.
  logic [DATA_W-1:0] mem      [MEM_WORDS];
  logic [DATA_W-1:0] ldata    [NLINES * MAX_BLOCK_WORDS];
  logic [ADDR_W-1:0] ltag     [NLINES];
  logic [AGE_W-1:0]  lage     [NLINES];
  logic [NLINES-1:0] lvalid;
  logic [NLINES-1:0] ldirty;

  logic [4:0]        state;
  logic [4:0]        ret_state;
  req_t              req;
  logic [CLR_W-1:0]  clr_cnt;
  logic [2:0]        b_eff;
  logic [2:0]        s_eff;
  logic [1:0]        w_eff;
  logic [BCNT_W-1:0] words;
  logic [SCNT_W-1:0] nsets;
  logic [WCNT_W-1:0] nways;
  logic [SET_W-1:0]  set_idx;
  logic [ADDR_W-1:0] tag;
  logic [ADDR_W-1:0] base;
  logic [BW_W-1:0]   word_idx;
  logic [WCNT_W-1:0] way_cnt;
  logic [SCNT_W-1:0] set_cnt;
  logic [BCNT_W-1:0] wcnt;
  logic              hit_found;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  victim;
  logic [AGE_W-1:0]  oldest;
  logic [ADDR_W-1:0] vaddr;
  logic [LI_W-1:0]   li;
  logic [LI_W-1:0]   scan_li;
  logic [LI_W-1:0]   flush_li;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] ld_q;
  logic [ADDR_W-1:0] ltag_q;
  logic [AGE_W-1:0]  age_q;
  logic [AGE_W-1:0]  age_inc;
  logic              res_full;

  function automatic logic [2:0] fit3(input logic [2:0] l, input int maxl);
    logic [2:0] r;
    r = l;
    if (int'(l) > maxl) r = 3'(maxl);
    return r;
  endfunction

  // Clamp geometry to the hardware maximums.
  assign b_eff   = fit3(block_words_log2, BW_L2);
  assign s_eff   = fit3(sets_log2, SET_L2);
  assign w_eff   = 2'(fit3({1'b0, ways_log2}, WAY_L2));
  assign words   = BCNT_W'(1) << b_eff;
  assign nsets   = SCNT_W'(1) << s_eff;
  assign nways   = WCNT_W'(1) << w_eff;
  assign word_idx = BW_W'(req.address & ((ADDR_W'(1) << b_eff) - 1'b1));
  assign set_idx  = SET_W'((req.address >> b_eff) & ((ADDR_W'(1) << s_eff) - 1'b1));
  assign tag      = req.address >> ({1'b0, b_eff} + {1'b0, s_eff});
  assign base     = req.address & ~((ADDR_W'(1) << b_eff) - 1'b1);

  // Saturating age of the way under test.
  assign age_inc  = (age_q != '1) ? age_q + 1'b1 : age_q;

  function automatic logic [LI_W-1:0] mk_li(input logic [SET_W-1:0] s,
                                            input logic [WAY_W-1:0] w);
    logic [LINE_W-1:0] t;
    t = LINE_W'(s) * LINE_W'(MAX_WAYS) + LINE_W'(w);
    return LI_W'(t);
  endfunction

  function automatic logic [DA_W-1:0] mk_da(input logic [LI_W-1:0] l,
                                            input logic [BCNT_W-1:0] i);
    logic [DW_W-1:0] t;
    t = DW_W'(l) * DW_W'(MAX_BLOCK_WORDS) + DW_W'(i);
    return DA_W'(t);
  endfunction

  assign scan_li  = mk_li(set_idx, WAY_W'(way_cnt));
  assign flush_li = mk_li(SET_W'(set_cnt), WAY_W'(way_cnt));
  assign q_ready  = (state == ST_IDLE);
  assign res_valid = res_full;

  // Sequencer: one request at a time, moving memory words one at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      lvalid   <= '0;
      ldirty   <= '0;
      res_full <= 1'b0;
    end else begin
      if (res_full && res_ready) res_full <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          mem[MEM_AW'(clr_cnt)] <= '0;
          if (int'(clr_cnt) < NLINES) lage[LI_W'(clr_cnt)] <= '0;
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(MEM_WORDS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            req       <= q_req;
            way_cnt   <= '0;
            set_cnt   <= '0;
            hit_found <= 1'b0;
            victim    <= '0;
            oldest    <= '0;
            unique case (q_req.func)
              FUNC_PRELOAD: state <= ST_PRE;
              FUNC_FLUSH:   state <= ST_FLINE;
              default:      state <= ST_SCAN;
            endcase
          end
        end
        ST_PRE: begin
          mem[MEM_AW'(req.address)] <= req.write_data;
          res       <= '{ACT_PRELOAD, req.address, '0, 1'b1};
          res_full  <= 1'b1;
          ret_state <= ST_IDLE;
          state     <= ST_WAIT;
        end
        // Search ways one at a time: read tag and age, then compare and age.
        ST_SCAN: begin
          if (way_cnt == nways) begin
            if (hit_found) begin
              li    <= mk_li(set_idx, hit_way);
              state <= ST_ACC;
            end else begin
              li    <= mk_li(set_idx, victim);
              state <= ST_VICT;
            end
          end else begin
            ltag_q <= ltag[scan_li];
            age_q  <= lage[scan_li];
            state  <= ST_WREAD;
          end
        end
        ST_WREAD: begin
          if (!hit_found && lvalid[scan_li] && ltag_q == tag) begin
            hit_found     <= 1'b1;
            hit_way       <= WAY_W'(way_cnt);
            lage[scan_li] <= '0;
          end else begin
            lage[scan_li] <= age_inc;
            if (way_cnt == '0 || age_inc > oldest) begin
              victim <= WAY_W'(way_cnt);
              oldest <= age_inc;
            end
          end
          way_cnt <= way_cnt + 1'b1;
          state   <= ST_SCAN;
        end
        // Victim tag read, then address, writeback of a dirty victim, and eviction record.
        ST_VICT: begin
          ltag_q <= ltag[li];
          wcnt   <= '0;
          state  <= ST_VTAG;
        end
        ST_VTAG: begin
          vaddr <= ADDR_W'((ltag_q << s_eff | ADDR_W'(set_idx)) << b_eff);
          if (lvalid[li] && ldirty[li]) state <= ST_VREAD;
          else state <= ST_EVREC;
        end
        ST_VREAD: begin
          ld_q  <= ldata[mk_da(li, wcnt)];
          state <= ST_WB;
        end
        ST_WB: begin
          mem[MEM_AW'(vaddr + ADDR_W'(wcnt))] <= ld_q;
          wcnt <= wcnt + 1'b1;
          if (wcnt + 1'b1 == words) state <= ST_EVREC;
          else state <= ST_VREAD;
        end
        ST_EVREC: begin
          res <= '{(lvalid[li] && ldirty[li]) ? ACT_WRITEBACK : ACT_DISCARD,
                   lvalid[li] ? vaddr : '0, '0, 1'b0};
          res_full  <= 1'b1;
          wcnt      <= '0;
          ret_state <= ST_FREAD;
          state     <= ST_WAIT;
        end
        ST_FREAD: begin
          mem_q <= mem[MEM_AW'(base + ADDR_W'(wcnt))];
          state <= ST_FILL;
        end
        ST_FILL: begin
          ldata[mk_da(li, wcnt)] <= mem_q;
          wcnt <= wcnt + 1'b1;
          if (wcnt + 1'b1 == words) state <= ST_FREC;
          else state <= ST_FREAD;
        end
        ST_FREC: begin
          lvalid[li] <= 1'b1;
          ldirty[li] <= 1'b0;
          ltag[li]   <= tag;
          lage[li]   <= '0;
          res        <= '{ACT_FILL, base, '0, 1'b0};
          res_full   <= 1'b1;
          ret_state  <= ST_ACC;
          state      <= ST_WAIT;
        end
        ST_ACC: begin
          if (req.func == FUNC_READ) begin
            state <= ST_AREAD;
          end else begin
            ldata[mk_da(li, BCNT_W'(word_idx))] <= req.write_data;
            ldirty[li] <= 1'b1;
            res       <= '{ACT_FROM_CPU, base, '0, 1'b1};
            res_full  <= 1'b1;
            ret_state <= ST_IDLE;
            state     <= ST_WAIT;
          end
        end
        ST_AREAD: begin
          rd_word <= ldata[mk_da(li, BCNT_W'(word_idx))];
          state   <= ST_AREC;
        end
        ST_AREC: begin
          res       <= '{ACT_TO_CPU, base, rd_word, 1'b1};
          res_full  <= 1'b1;
          ret_state <= ST_IDLE;
          state     <= ST_WAIT;
        end
        // Flush: walk sets and ways, write back dirty lines, then invalidate all lines and report.
        ST_FLINE: begin
          if (set_cnt == nsets) begin
            lvalid    <= '0;
            ldirty    <= '0;
            res       <= '{ACT_FLUSH, '0, '0, 1'b1};
            res_full  <= 1'b1;
            ret_state <= ST_IDLE;
            state     <= ST_WAIT;
          end else if (way_cnt == nways) begin
            way_cnt <= '0;
            set_cnt <= set_cnt + 1'b1;
          end else if (lvalid[flush_li] && ldirty[flush_li]) begin
            li     <= flush_li;
            ltag_q <= ltag[flush_li];
            wcnt   <= '0;
            state  <= ST_FNEXT;
          end else begin
            way_cnt <= way_cnt + 1'b1;
          end
        end
        ST_FNEXT: begin
          vaddr <= ADDR_W'((ltag_q << s_eff | ADDR_W'(set_cnt)) << b_eff);
          state <= ST_FREADW;
        end
        ST_FREADW: begin
          ld_q  <= ldata[mk_da(li, wcnt)];
          state <= ST_FWB;
        end
        ST_FWB: begin
          mem[MEM_AW'(vaddr + ADDR_W'(wcnt))] <= ld_q;
          wcnt <= wcnt + 1'b1;
          if (wcnt + 1'b1 == words) begin
            way_cnt <= way_cnt + 1'b1;
            state   <= ST_FLINE;
          end else begin
            state <= ST_FREADW;
          end
        end
        // Hold until the result register frees.
        ST_WAIT: begin
          if (!res_full || res_ready) state <= ret_state;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/set_assoc_writeback_lru_cache_top.sv
// Top level of the set-associative write-back cache with backing memory.
// Word-addressed write-back, write-allocate cache in front of an internal backing memory.
// After reset the backing memory is cleared one word a cycle while the engine takes no
// item. A request queue parts the input from a sequencing engine that handles one
// item at a time: a lookup walks the ways of the set one way at a time (tag and age
// read, then compare and age update), a writeback or fill moves one word at a time
// (read, then write), and a flush walks every line of the current geometry. Results
// (eviction record, fill, access, flush, preload) leave through a one-item register,
// and a stalled result holds the engine in its wait state until the receiver takes it.
module set_assoc_writeback_lru_cache_top #(
  parameter int MEM_WORDS       = 65536,
  parameter int MAX_BLOCK_WORDS = 16,
  parameter int MAX_SETS        = 16,
  parameter int MAX_WAYS        = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // func[1:0], address[17:2], write_data[49:18], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // action[2:0], block_address[18:3], read_data[50:19], zero
  output logic        m_tlast
);
  import salc_pkg::*;

  logic [2:0] block_words_log2;
  logic [2:0] sets_log2;
  logic [1:0] ways_log2;
  req_t       in_req;
  req_t       q_req;
  logic       q_valid;
  logic       q_ready;
  res_t       res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_words_log2 <= 3'd2;
      sets_log2        <= 3'd2;
      ways_log2        <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK: block_words_log2 <= cfg_data;
        CFG_SETS:  sets_log2 <= cfg_data;
        CFG_WAYS:  ways_log2 <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_req = '{s_tdata[1:0], s_tdata[17:2], s_tdata[49:18]};

  salc_front #(.DEPTH_LOG2(1)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  salc_back #(
    .MEM_WORDS(MEM_WORDS), .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS),
    .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)
  ) u_back (
    .clk(clk), .rst(rst),
    .block_words_log2(block_words_log2), .sets_log2(sets_log2), .ways_log2(ways_log2),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {5'd0, res.read_data, res.block_address, res.action};
  assign m_tlast = res.last;

endmodule
